FILE: rtl/ssp_pkg.sv
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 4;
  localparam int PATTERN_BYTES  = 16;
  localparam int LENGTH_BITS    = 5;
  localparam int LIMIT_BITS     = 32;
  localparam int CMP_BITS       = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW    = 4'd0,
    REG_PATTERN_HIGH   = 4'd1,
    REG_PATTERN_LENGTH = 4'd2,
    REG_SEARCH_LIMIT   = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  match_found;
    logic                  first_match_res;
    logic [FIELD_BITS-1:0] start_offset;
    logic [FIELD_BITS-1:0] start_line;
    logic [FIELD_BITS-1:0] start_column;
    logic [FIELD_BITS-1:0] end_offset;
    logic                  end_of_document;
  } ssp_result_t;

endpackage

FILE: rtl/ssp_if.sv
`timescale 1ns / 1ps
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       last_byte;

  modport source (output valid, output doc_byte, output last_byte, input ready);
  modport sink (input valid, input doc_byte, input last_byte, output ready);
endinterface

interface ssp_out_if import ssp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  match_found;
  logic                  first_match_res;
  logic [FIELD_BITS-1:0] start_offset;
  logic [FIELD_BITS-1:0] start_line;
  logic [FIELD_BITS-1:0] start_column;
  logic [FIELD_BITS-1:0] end_offset;
  logic                  end_of_document;

  modport source (
    output valid, output match_found, output first_match_res, output start_offset,
    output start_line, output start_column, output end_offset, output end_of_document,
    input ready
  );
  modport sink (
    input valid, input match_found, input first_match_res, input start_offset,
    input start_line, input start_column, input end_offset, input end_of_document,
    output ready
  );
endinterface

interface ssp_cfg_if import ssp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ssp_cell.sv
`timescale 1ns / 1ps
module ssp_cell import ssp_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl_i,
  input  logic                active_i,
  input  logic [7:0]          pat_byte_i,
  input  logic                hit_i,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic [POS_BITS-1:0] line_i,
  input  logic [POS_BITS-1:0] column_i,
  output logic                hit_o,
  output logic                valid_o,
  output logic [7:0]          byte_o,
  output logic [POS_BITS-1:0] line_o,
  output logic [POS_BITS-1:0] column_o
);

  logic                valid_r;
  logic [7:0]          byte_r;
  logic [POS_BITS-1:0] line_r;
  logic [POS_BITS-1:0] column_r;

  // The comparison looks at the entry as it stands once the new byte has moved in.
  assign hit_o = hit_i & (~active_i | (valid_i & (byte_i == pat_byte_i)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_r <= valid_i & ~ctrl_i.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.shift) begin
      byte_r   <= byte_i;
      line_r   <= line_i;
      column_r <= column_i;
    end
  end

  assign valid_o  = valid_r;
  assign byte_o   = byte_r;
  assign line_o   = line_r;
  assign column_o = column_r;

endmodule

FILE: rtl/ssp_out_stage.sv
`timescale 1ns / 1ps
module ssp_out_stage import ssp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  ssp_result_t   push_data_i,
  output logic          ready_o,
  ssp_out_if.source     out_chan
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  ssp_result_t out_data_r, skid_data_r;
  logic        take;
  logic        load_main, load_main_skid, load_skid;

  assign take    = out_valid_r & out_chan.ready;
  assign ready_o = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main      = 1'b0;
    load_main_skid = 1'b0;
    load_skid      = 1'b0;
    priority if (skid_valid_r && take) begin
      load_main_skid = 1'b1;
      skid_valid_nxt = 1'b0;
    end else if (push_i) begin
      if (!out_valid_r || take) begin
        load_main     = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main_skid) begin
      out_data_r <= skid_data_r;
    end else if (load_main) begin
      out_data_r <= push_data_i;
    end
    if (load_skid) begin
      skid_data_r <= push_data_i;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.match_found     = out_data_r.match_found;
  assign out_chan.first_match_res = out_data_r.first_match_res;
  assign out_chan.start_offset    = out_data_r.start_offset;
  assign out_chan.start_line      = out_data_r.start_line;
  assign out_chan.start_column    = out_data_r.start_column;
  assign out_chan.end_offset      = out_data_r.end_offset;
  assign out_chan.end_of_document = out_data_r.end_of_document;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid word held while the output register is empty.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push_i)
    else $error("Word accepted while both output registers are full.");

endmodule

FILE: rtl/substring_search_with_position_unit.sv
`timescale 1ns / 1ps
// Streaming substring search with byte position tracking.
// The in_chan channel carries one document byte per word with a flag on the
// final byte; out_chan returns exactly one result word for every input word.
// The cfg_chan channel writes the word bytes, the word length and the search
// limit; it is always ready and should be written only while the block is idle.
// A row of MAX_WORD_BYTES cells holds the recent bytes with their line and
// column; active cells each compare a byte with the configured word in parallel.
// Each result is registered in the output stage before it appears on out_chan,
// and throughput is one word per cycle while the receiver does not stall, set
// by the combinational compare along the cell row.
// The output has a two-entry register stage, so an input word is still taken
// while a result waits; when the receiver stalls, in_chan.ready drops once
// both entries are full and rises again as soon as one is taken.
// Synchronous reset clears the window and the registers but sets the word length
// and the counters to one. After a final byte the window, the counters and the
// first-match flag return to their reset values while the registers keep theirs.
module substring_search_with_position_unit import ssp_pkg::*; #(
  parameter int MAX_WORD_BYTES = 16,
  parameter int POSITION_BITS  = 32
) (
  input logic       clk,
  input logic       rst_n,
  ssp_in_if.sink    in_chan,
  ssp_out_if.source out_chan,
  ssp_cfg_if.sink   cfg_chan
);

  localparam int IdxW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam logic [LENGTH_BITS-1:0] MaxLen = LENGTH_BITS'(MAX_WORD_BYTES);

  logic [CFG_DATA_BITS-1:0] pattern_low_r, pattern_high_r;
  logic [LENGTH_BITS-1:0]   pattern_length_r;
  logic [LIMIT_BITS-1:0]    search_limit_r;

  logic [POSITION_BITS-1:0] offset_r, offset_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] column_r, column_nxt;
  logic                     seen_r, seen_nxt;

  logic        accept;
  logic        stage_ready;
  cell_ctrl_t  ctrl;
  logic [IdxW-1:0] last_idx;
  logic [8*PATTERN_BYTES-1:0] pattern;
  logic        limit_ok;
  logic        hit;
  ssp_result_t result;

  logic                     chain_hit    [0:MAX_WORD_BYTES];
  logic                     chain_valid  [0:MAX_WORD_BYTES];
  logic [7:0]               chain_byte   [0:MAX_WORD_BYTES];
  logic [POSITION_BITS-1:0] chain_line   [0:MAX_WORD_BYTES];
  logic [POSITION_BITS-1:0] chain_column [0:MAX_WORD_BYTES];

  logic [POSITION_BITS-1:0]            start_off_pos;
  logic [POSITION_BITS+FIELD_BITS-1:0] start_off_ext, start_line_ext;
  logic [POSITION_BITS+FIELD_BITS-1:0] start_col_ext, end_off_ext;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= LENGTH_BITS'(1);
      search_limit_r   <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_chan.data;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_chan.data;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_chan.data[LENGTH_BITS-1:0];
        REG_SEARCH_LIMIT:   search_limit_r   <= cfg_chan.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pattern_length_r <= LENGTH_BITS'(1)) begin
      last_idx = '0;
    end else if (pattern_length_r > MaxLen) begin
      last_idx = IdxW'(MAX_WORD_BYTES - 1);
    end else begin
      last_idx = IdxW'(pattern_length_r - LENGTH_BITS'(1));
    end
  end

  assign pattern  = {pattern_high_r, pattern_low_r};
  assign in_chan.ready = stage_ready;
  assign accept   = in_chan.valid & stage_ready;
  assign ctrl     = '{shift: accept, clear: in_chan.last_byte};
  assign limit_ok = (search_limit_r == '0) ||
                    (CMP_BITS'(offset_r) < CMP_BITS'(search_limit_r));

  assign chain_hit[0]    = limit_ok;
  assign chain_valid[0]  = 1'b1;
  assign chain_byte[0]   = in_chan.doc_byte;
  assign chain_line[0]   = line_r;
  assign chain_column[0] = column_r;

  for (genvar i = 0; i < MAX_WORD_BYTES; i++) begin : g_cell
    logic       active;
    logic [3:0] pat_idx;
    logic [7:0] pat_byte;

    assign active   = (IdxW'(i) <= last_idx);
    assign pat_idx  = 4'(last_idx) - 4'(i);
    assign pat_byte = pattern[8*pat_idx +: 8];

    ssp_cell #(
      .POS_BITS(POSITION_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .active_i   (active),
      .pat_byte_i (pat_byte),
      .hit_i      (chain_hit[i]),
      .valid_i    (chain_valid[i]),
      .byte_i     (chain_byte[i]),
      .line_i     (chain_line[i]),
      .column_i   (chain_column[i]),
      .hit_o      (chain_hit[i+1]),
      .valid_o    (chain_valid[i+1]),
      .byte_o     (chain_byte[i+1]),
      .line_o     (chain_line[i+1]),
      .column_o   (chain_column[i+1])
    );
  end

  assign hit           = chain_hit[MAX_WORD_BYTES];
  assign start_off_pos = offset_r - POSITION_BITS'(last_idx);
  assign start_off_ext = {{FIELD_BITS{1'b0}}, start_off_pos};
  assign start_line_ext = {{FIELD_BITS{1'b0}}, chain_line[last_idx]};
  assign start_col_ext  = {{FIELD_BITS{1'b0}}, chain_column[last_idx]};
  assign end_off_ext    = {{FIELD_BITS{1'b0}}, offset_r};

  always_comb begin
    result.match_found     = hit;
    result.first_match_res = hit & ~seen_r;
    result.start_offset    = hit ? start_off_ext[FIELD_BITS-1:0] : '0;
    result.start_line      = hit ? start_line_ext[FIELD_BITS-1:0] : '0;
    result.start_column    = hit ? start_col_ext[FIELD_BITS-1:0] : '0;
    result.end_offset      = end_off_ext[FIELD_BITS-1:0];
    result.end_of_document = in_chan.last_byte;
  end

  always_comb begin
    offset_nxt = offset_r;
    line_nxt   = line_r;
    column_nxt = column_r;
    seen_nxt   = seen_r;
    if (accept) begin
      if (in_chan.last_byte) begin
        offset_nxt = POSITION_BITS'(1);
        line_nxt   = POSITION_BITS'(1);
        column_nxt = POSITION_BITS'(1);
        seen_nxt   = 1'b0;
      end else begin
        offset_nxt = (offset_r == '1) ? offset_r : offset_r + 1'b1;
        seen_nxt   = seen_r | hit;
        if (in_chan.doc_byte == NEWLINE_BYTE) begin
          line_nxt   = (line_r == '1) ? line_r : line_r + 1'b1;
          column_nxt = POSITION_BITS'(1);
        end else begin
          column_nxt = (column_r == '1) ? column_r : column_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= POSITION_BITS'(1);
      line_r   <= POSITION_BITS'(1);
      column_r <= POSITION_BITS'(1);
      seen_r   <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      line_r   <= line_nxt;
      column_r <= column_nxt;
      seen_r   <= seen_nxt;
    end
  end

  ssp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (accept),
    .push_data_i (result),
    .ready_o     (stage_ready),
    .out_chan    (out_chan)
  );

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last_byte |=> offset_r == POSITION_BITS'(1) && !seen_r)
    else $error("Document state not restored after the final byte.");

  a_offset_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_chan.last_byte && offset_r != '1 |=>
      offset_r == $past(offset_r) + 1'b1)
    else $error("Offset counter did not advance by one.");

  a_first_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_chan.last_byte && result.first_match_res |=> seen_r)
    else $error("First occurrence not remembered.");

endmodule
